// ===== rtl/nau_pkg.sv =====
// shared types, constants and sigmoid segment table for the activation unit
package nau_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int FRAC_BITS        = 12;
  localparam int SIGMOID_SEGMENTS = 64;
  localparam int SEG_W            = $clog2(SIGMOID_SEGMENTS);
  localparam int T_W              = FRAC_BITS + 4;
  localparam int P_W              = T_W + SEG_W;
  localparam int CLAMP_W          = (FRAC_BITS + 5 > SAMPLE_W + 1) ? FRAC_BITS + 5 : SAMPLE_W + 1;
  localparam int Q16_W            = 17;
  localparam int PROD_W           = Q16_W + T_W;
  localparam int LEAKY_NUM        = 41;
  localparam int LEAKY_SHIFT      = 12;
  localparam int LEAKY_W          = SAMPLE_W + 7;
  localparam int MASTER_SIZE      = 257;
  localparam int QUEUE_DEPTH      = 2;
  localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W           = 3;
  localparam int DATA_W           = 32;
  localparam int OUT_EXT_W        = 18;

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  localparam logic signed [CLAMP_W-1:0] SIG_LO = CLAMP_W'(-(8 << FRAC_BITS));
  localparam logic signed [CLAMP_W-1:0] SIG_HI = CLAMP_W'((8 << FRAC_BITS) - 1);

  localparam logic REG_ACT_MODE = 1'b0;

  typedef enum logic [1:0] {
    ACT_RELU    = 2'd0,
    ACT_LEAKY   = 2'd1,
    ACT_SIGMOID = 2'd2,
    ACT_TANH    = 2'd3
  } act_mode_e;

  typedef logic [MASTER_SIZE-1:0][Q16_W-1:0] master_t;

  typedef struct packed {
    logic [Q16_W-1:0] y0;
    logic [Q16_W-1:0] dy;
  } seg_entry_t;

  typedef seg_entry_t [SIGMOID_SEGMENTS-1:0] seg_table_t;

  // one classified sample as it waits between front and back
  typedef struct packed {
    act_mode_e           mode;
    logic                last;
    logic [SAMPLE_W-1:0] simple;
    logic [SEG_W-1:0]    seg;
    logic [T_W-1:0]      frac;
  } entry_t;

  // logistic over [-8,8] in q16, 1/16 steps, long division by shift and subtract
  function automatic master_t build_master();
    master_t     m;
    logic [63:0] e;
    logic [63:0] d;
    logic [63:0] num;
    logic [63:0] q;
    logic [63:0] rem;
    int          j;
    int          b;
    m = '0;
    e = 64'd1 << 31;
    for (j = 0; j <= 128; j++) begin
      d   = (64'd1 << 31) + e;
      num = (64'd1 << 47) + (d >> 1);
      q   = '0;
      rem = '0;
      for (b = 63; b >= 0; b--) begin
        rem = {rem[62:0], num[b]};
        if (rem >= d) begin
          rem  = rem - d;
          q[b] = 1'b1;
        end
      end
      m[128 + j] = q[Q16_W-1:0];
      m[128 - j] = 17'd65536 - q[Q16_W-1:0];
      e = (e * EXP_STEP_Q32 + (64'd1 << 31)) >> 32;
    end
    return m;
  endfunction

  localparam master_t MASTER = build_master();

  function automatic seg_table_t build_seg();
    seg_table_t       s;
    int               k;
    int               i0;
    int               i1;
    logic [Q16_W-1:0] y0;
    logic [Q16_W-1:0] y1;
    s = '0;
    for (k = 0; k < SIGMOID_SEGMENTS; k++) begin
      i0 = (k * 256) / SIGMOID_SEGMENTS;
      i1 = ((k + 1) * 256) / SIGMOID_SEGMENTS;
      if (i0 > 256) i0 = 256;
      if (i1 > 256) i1 = 256;
      y0 = MASTER[i0];
      y1 = MASTER[i1];
      if (y1 < y0) y1 = y0;
      s[k].y0 = y0;
      s[k].dy = y1 - y0;
    end
    return s;
  endfunction

  localparam seg_table_t SEG_TABLE = build_seg();

endpackage

// ===== rtl/nau_front.sv =====
// front end: takes samples, works out relu/leaky results and sigmoid segment
module nau_front (
  input  nau_pkg::act_mode_e           mode_i,
  input  logic                         sample_valid_i,
  output logic                         sample_stall_o,
  input  logic [nau_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                         last_in_i,
  input  logic                         queue_full_i,
  output logic                         push_o,
  output nau_pkg::entry_t              entry_o
);

  logic signed [nau_pkg::SAMPLE_W-1:0] x;
  logic signed [nau_pkg::SAMPLE_W-1:0] x_dbl;
  logic signed [nau_pkg::SAMPLE_W-1:0] x_sig;
  logic signed [nau_pkg::CLAMP_W-1:0]  x_ext;
  logic signed [nau_pkg::CLAMP_W-1:0]  x_clamp;
  logic        [nau_pkg::CLAMP_W-1:0]  t_full;
  logic        [nau_pkg::T_W-1:0]      t;
  logic        [nau_pkg::P_W-1:0]      p;
  logic signed [nau_pkg::LEAKY_W-1:0]  leaky_prod;
  logic signed [nau_pkg::LEAKY_W-1:0]  leaky_shr;
  logic        [nau_pkg::SAMPLE_W-1:0] simple;

  assign x              = $signed(sample_in_i);
  assign sample_stall_o = queue_full_i;
  assign push_o         = sample_valid_i && !queue_full_i;

  always_comb begin
    // doubling for tanh, saturating at the sample range
    if (x[nau_pkg::SAMPLE_W-1] != x[nau_pkg::SAMPLE_W-2]) begin
      x_dbl = x[nau_pkg::SAMPLE_W-1] ? {1'b1, {(nau_pkg::SAMPLE_W-1){1'b0}}}
                                     : {1'b0, {(nau_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      x_dbl = {x[nau_pkg::SAMPLE_W-2:0], 1'b0};
    end
    x_sig = (mode_i == nau_pkg::ACT_TANH) ? x_dbl : x;
    x_ext = {{(nau_pkg::CLAMP_W-nau_pkg::SAMPLE_W){x_sig[nau_pkg::SAMPLE_W-1]}}, x_sig};
    if (x_ext < nau_pkg::SIG_LO) begin
      x_clamp = nau_pkg::SIG_LO;
    end else if (x_ext > nau_pkg::SIG_HI) begin
      x_clamp = nau_pkg::SIG_HI;
    end else begin
      x_clamp = x_ext;
    end
    t_full = x_clamp - nau_pkg::SIG_LO;
    t      = t_full[nau_pkg::T_W-1:0];
    p      = {{nau_pkg::SEG_W{1'b0}}, t} * nau_pkg::P_W'(nau_pkg::SIGMOID_SEGMENTS);
  end

  always_comb begin
    leaky_prod = {{(nau_pkg::LEAKY_W-nau_pkg::SAMPLE_W){x[nau_pkg::SAMPLE_W-1]}}, x}
                 * $signed(nau_pkg::LEAKY_W'(nau_pkg::LEAKY_NUM));
    leaky_shr  = leaky_prod >>> nau_pkg::LEAKY_SHIFT;
    if (x > 0) begin
      simple = x;
    end else if (mode_i == nau_pkg::ACT_LEAKY) begin
      simple = leaky_shr[nau_pkg::SAMPLE_W-1:0];
    end else begin
      simple = '0;
    end
  end

  always_comb begin
    entry_o.mode   = mode_i;
    entry_o.last   = last_in_i;
    entry_o.simple = simple;
    entry_o.seg    = p[nau_pkg::T_W +: nau_pkg::SEG_W];
    entry_o.frac   = p[nau_pkg::T_W-1:0];
  end

endmodule

// ===== rtl/nau_queue.sv =====
// short request queue between front and back
module nau_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nau_pkg::entry_t entry_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            take_i,
  output nau_pkg::entry_t entry_o
);

  nau_pkg::entry_t             mem_q [nau_pkg::QUEUE_DEPTH];
  logic [nau_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [nau_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [nau_pkg::QCNT_W-1:0]  count_q, count_d;
  logic                        pop;

  localparam logic [nau_pkg::QPTR_W-1:0] LAST_PTR = nau_pkg::QPTR_W'(nau_pkg::QUEUE_DEPTH - 1);
  localparam logic [nau_pkg::QCNT_W-1:0] FULL_CNT = nau_pkg::QCNT_W'(nau_pkg::QUEUE_DEPTH);

  assign full_o  = (count_q == FULL_CNT);
  assign valid_o = (count_q != '0);
  assign pop     = valid_o && take_i;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== rtl/nau_back.sv =====
// back end: segment lookup and interpolation, tanh scaling, output register
module nau_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  nau_pkg::entry_t              q_entry_i,
  output logic                         take_o,
  output logic                         result_valid_o,
  input  logic                         result_stall_i,
  output logic [nau_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                         last_out_o
);

  logic                         en_out;
  logic                         en_s1;
  logic                         s1_valid_q;
  logic                         out_valid_q;
  nau_pkg::act_mode_e           s1_mode_q;
  logic                         s1_last_q;
  logic [nau_pkg::SAMPLE_W-1:0] s1_simple_q;
  logic [nau_pkg::Q16_W-1:0]    s1_y0_q;
  logic [nau_pkg::PROD_W-1:0]   s1_prod_q;
  logic [nau_pkg::PROD_W-1:0]   prod_d;
  nau_pkg::seg_entry_t          seg_ent;
  logic [nau_pkg::SAMPLE_W-1:0] sample_q, sample_d;
  logic                         last_q;
  logic [nau_pkg::OUT_EXT_W-1:0] y_sum;
  logic [nau_pkg::OUT_EXT_W-1:0] y_rnd;
  logic [nau_pkg::OUT_EXT_W-1:0] sig_val;
  logic [nau_pkg::OUT_EXT_W-1:0] tanh_val;

  assign en_out = !out_valid_q || !result_stall_i;
  assign en_s1  = !s1_valid_q || en_out;
  assign take_o = en_s1;

  assign seg_ent = nau_pkg::SEG_TABLE[q_entry_i.seg];
  assign prod_d  = {{nau_pkg::T_W{1'b0}}, seg_ent.dy}
                   * {{nau_pkg::Q16_W{1'b0}}, q_entry_i.frac};

  always_comb begin
    y_sum    = {1'b0, s1_y0_q}
               + nau_pkg::OUT_EXT_W'(s1_prod_q[nau_pkg::PROD_W-1:nau_pkg::T_W]);
    // round half up from q16 to the sample format
    y_rnd    = y_sum + (nau_pkg::OUT_EXT_W'(1) << (15 - nau_pkg::FRAC_BITS));
    sig_val  = y_rnd >> (16 - nau_pkg::FRAC_BITS);
    tanh_val = (sig_val << 1) - (nau_pkg::OUT_EXT_W'(1) << nau_pkg::FRAC_BITS);
    case (s1_mode_q)
      nau_pkg::ACT_SIGMOID: sample_d = sig_val[nau_pkg::SAMPLE_W-1:0];
      nau_pkg::ACT_TANH:    sample_d = tanh_val[nau_pkg::SAMPLE_W-1:0];
      default:              sample_d = s1_simple_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_valid_q <= q_valid_i;
      end
      if (en_out) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_s1 && q_valid_i) begin
      s1_mode_q   <= q_entry_i.mode;
      s1_last_q   <= q_entry_i.last;
      s1_simple_q <= q_entry_i.simple;
      s1_y0_q     <= seg_ent.y0;
      s1_prod_q   <= prod_d;
    end
    if (en_out && s1_valid_q) begin
      sample_q <= sample_d;
      last_q   <= s1_last_q;
    end
  end

  assign result_valid_o = out_valid_q;
  assign sample_out_o   = sample_q;
  assign last_out_o     = last_q;

endmodule

// ===== rtl/neural_activation_unit.sv =====
// activation unit top level: mode register, front end, queue and back end
// path: after its sample is accepted, a result passes the queue, then the lookup-and-multiply and output registers
// throughput: one sample per cycle while the receiver does not stall, set by the single-entry-per-cycle queue
// and the two back-end stages (segment lookup and multiply, then round)
// reset: mode returns to relu, queue and pipeline empty; no table clearing
module neural_activation_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nau_pkg::ADDR_W-1:0]   paddr,
  input  logic [nau_pkg::DATA_W-1:0]   pwdata,
  output logic [nau_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         sample_valid_i,
  output logic                         sample_stall_o,
  input  logic [nau_pkg::SAMPLE_W-1:0] sample_in_i,
  input  logic                         last_in_i,
  output logic                         result_valid_o,
  input  logic                         result_stall_i,
  output logic [nau_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic                         last_out_o
);

  nau_pkg::act_mode_e act_mode_q;
  nau_pkg::entry_t    push_entry;
  nau_pkg::entry_t    pop_entry;
  logic               push;
  logic               queue_full;
  logic               queue_valid;
  logic               take;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == nau_pkg::REG_ACT_MODE);

  always_comb begin
    if (paddr[2] == nau_pkg::REG_ACT_MODE) begin
      prdata = {{(nau_pkg::DATA_W-2){1'b0}}, act_mode_q};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_mode_q <= nau_pkg::ACT_RELU;
    end else if (cfg_write) begin
      act_mode_q <= nau_pkg::act_mode_e'(pwdata[1:0]);
    end
  end

  nau_front u_front (
    .mode_i         (act_mode_q),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_in_i    (sample_in_i),
    .last_in_i      (last_in_i),
    .queue_full_i   (queue_full),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  nau_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .take_i  (take),
    .entry_o (pop_entry)
  );

  nau_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (queue_valid),
    .q_entry_i      (pop_entry),
    .take_o         (take),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .sample_out_o   (sample_out_o),
    .last_out_o     (last_out_o)
  );

endmodule

// ===== dv/tb_neural_activation_unit.sv =====
// self-checking testbench for the streaming activation unit
`timescale 1ns / 100ps

module tb_neural_activation_unit;

  localparam int          CYCLE_LIMIT    = 400000;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          PHASE_ITEMS    = 160;
  localparam int          SETTLE_CYCLES  = 6;
  localparam int          SLOPE_NUM      = 41;
  localparam int          SLOPE_SHIFT    = 12;
  localparam logic [63:0] EXP_STEP       = 64'd4034748382;
  localparam logic [nau_pkg::ADDR_W-1:0] ADDR_ACT_MODE = 3'd0;
  localparam logic [nau_pkg::ADDR_W-1:0] ADDR_UNUSED   = 3'd4;

  typedef struct packed {
    logic [nau_pkg::SAMPLE_W-1:0] sample;
    logic                         last;
  } act_result_t;

  typedef struct {
    nau_pkg::act_mode_e           mode;
    logic [nau_pkg::SAMPLE_W-1:0] sample;
    logic                         last;
    logic                         known;
    logic [nau_pkg::SAMPLE_W-1:0] want;
  } probe_t;

  logic                         clk            = 1'b0;
  logic                         rst_ni         = 1'b0;
  logic                         psel           = 1'b0;
  logic                         penable        = 1'b0;
  logic                         pwrite         = 1'b0;
  logic [nau_pkg::ADDR_W-1:0]   paddr          = '0;
  logic [nau_pkg::DATA_W-1:0]   pwdata         = '0;
  logic [nau_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         sample_valid_i = 1'b0;
  logic                         sample_stall_o;
  logic [nau_pkg::SAMPLE_W-1:0] sample_in_i    = '0;
  logic                         last_in_i      = 1'b0;
  logic                         result_valid_o;
  logic                         result_stall_i = 1'b0;
  logic [nau_pkg::SAMPLE_W-1:0] sample_out_o;
  logic                         last_out_o;

  act_result_t        pending_results[$];
  act_result_t        oldest;
  int unsigned        logistic_q16 [0:256];
  nau_pkg::act_mode_e cur_mode = nau_pkg::ACT_RELU;
  int                 failures = 0;
  int                 cycle_count = 0;
  int                 results_checked = 0;
  int                 marks_sent = 0;
  int                 mode_writes = 0;
  int                 items_per_mode [4] = '{0, 0, 0, 0};
  bit                 hold_request = 1'b0;

  nau_pkg::act_mode_e phase_plan [0:7] = '{
    nau_pkg::ACT_TANH, nau_pkg::ACT_RELU, nau_pkg::ACT_SIGMOID, nau_pkg::ACT_LEAKY,
    nau_pkg::ACT_TANH, nau_pkg::ACT_SIGMOID, nau_pkg::ACT_RELU, nau_pkg::ACT_LEAKY
  };

  probe_t probes [0:20] = '{
    '{nau_pkg::ACT_RELU,    16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
    '{nau_pkg::ACT_RELU,    16'h8000, 1'b0, 1'b1, 16'h0000},
    '{nau_pkg::ACT_RELU,    16'h0000, 1'b1, 1'b1, 16'h0000},
    '{nau_pkg::ACT_RELU,    16'h0001, 1'b0, 1'b1, 16'h0001},
    '{nau_pkg::ACT_RELU,    16'hFFFF, 1'b1, 1'b1, 16'h0000},
    '{nau_pkg::ACT_LEAKY,   16'h7FFF, 1'b0, 1'b1, 16'h7FFF},
    '{nau_pkg::ACT_LEAKY,   16'h8000, 1'b0, 1'b1, 16'hFEB8},
    '{nau_pkg::ACT_LEAKY,   16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
    '{nau_pkg::ACT_LEAKY,   16'hFF9C, 1'b1, 1'b1, 16'hFFFE},
    '{nau_pkg::ACT_LEAKY,   16'h0000, 1'b0, 1'b1, 16'h0000},
    '{nau_pkg::ACT_SIGMOID, 16'h0000, 1'b0, 1'b1, 16'h0800},
    '{nau_pkg::ACT_SIGMOID, 16'h8000, 1'b0, 1'b0, 16'h0000},
    '{nau_pkg::ACT_SIGMOID, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
    '{nau_pkg::ACT_SIGMOID, 16'h1234, 1'b0, 1'b0, 16'h0000},
    '{nau_pkg::ACT_SIGMOID, 16'hF000, 1'b0, 1'b0, 16'h0000},
    '{nau_pkg::ACT_TANH,    16'h0000, 1'b0, 1'b1, 16'h0000},
    '{nau_pkg::ACT_TANH,    16'h7FFF, 1'b0, 1'b0, 16'h0000},
    '{nau_pkg::ACT_TANH,    16'h8000, 1'b0, 1'b0, 16'h0000},
    '{nau_pkg::ACT_TANH,    16'h4000, 1'b0, 1'b0, 16'h0000},
    '{nau_pkg::ACT_TANH,    16'hC000, 1'b1, 1'b0, 16'h0000},
    '{nau_pkg::ACT_TANH,    16'h0100, 1'b0, 1'b0, 16'h0000}
  };

  neural_activation_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .sample_valid_i (sample_valid_i),
    .sample_stall_o (sample_stall_o),
    .sample_in_i    (sample_in_i),
    .last_in_i      (last_in_i),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .sample_out_o   (sample_out_o),
    .last_out_o     (last_out_o)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // piecewise-linear logistic, result in FRAC_BITS fraction bits
  function automatic int sigmoid_q(int x);
    int                lo;
    int                hi;
    longint unsigned   t;
    longint unsigned   p;
    longint unsigned   f;
    longint unsigned   seg;
    longint unsigned   i0;
    longint unsigned   i1;
    longint unsigned   y0;
    longint unsigned   y1;
    longint unsigned   y;
    lo = -(8 << nau_pkg::FRAC_BITS);
    hi = (8 << nau_pkg::FRAC_BITS) - 1;
    if (x < lo) x = lo;
    if (x > hi) x = hi;
    t   = longint'(x - lo);
    p   = t * nau_pkg::SIGMOID_SEGMENTS;
    seg = p >> (nau_pkg::FRAC_BITS + 4);
    f   = p & ((64'd1 << (nau_pkg::FRAC_BITS + 4)) - 1);
    i0  = (seg * 256) / nau_pkg::SIGMOID_SEGMENTS;
    i1  = ((seg + 1) * 256) / nau_pkg::SIGMOID_SEGMENTS;
    if (i0 > 256) i0 = 256;
    if (i1 > 256) i1 = 256;
    y0 = logistic_q16[i0];
    y1 = logistic_q16[i1];
    if (y1 < y0) y1 = y0;
    y = y0 + (((y1 - y0) * f) >> (nau_pkg::FRAC_BITS + 4));
    y = (y + (64'd1 << (15 - nau_pkg::FRAC_BITS))) >> (16 - nau_pkg::FRAC_BITS);
    return int'(y);
  endfunction

  function automatic logic [nau_pkg::SAMPLE_W-1:0] activate(
    nau_pkg::act_mode_e mode, logic [nau_pkg::SAMPLE_W-1:0] raw);
    int xi;
    int x2;
    int r;
    xi = $signed(raw);
    case (mode)
      nau_pkg::ACT_RELU: begin
        r = (xi > 0) ? xi : 0;
      end
      nau_pkg::ACT_LEAKY: begin
        // floor shift, so small negatives land on -1 rather than zero
        r = (xi > 0) ? xi : ((xi * SLOPE_NUM) >>> SLOPE_SHIFT);
      end
      nau_pkg::ACT_SIGMOID: begin
        r = sigmoid_q(xi);
      end
      default: begin
        x2 = 2 * xi;
        if (x2 > 32767) x2 = 32767;
        if (x2 < -32768) x2 = -32768;
        r = 2 * sigmoid_q(x2) - (1 << nau_pkg::FRAC_BITS);
      end
    endcase
    return r[nau_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic logic [nau_pkg::SAMPLE_W-1:0] pick_sample();
    logic [nau_pkg::SAMPLE_W-1:0] s;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 5))
          0: s = 16'h7FFF;
          1: s = 16'h8000;
          2: s = 16'h0000;
          3: s = 16'h0001;
          4: s = 16'hFFFF;
          default: s = 16'h0001 << $urandom_range(0, 15);
        endcase
      end
      1, 2, 3: begin
        // around zero, where the curves bend
        s = 16'($urandom_range(0, 16383)) - 16'd8192;
      end
      default: begin
        s = 16'($urandom());
      end
    endcase
    return s;
  endfunction

  task automatic apb_write(input logic [nau_pkg::ADDR_W-1:0] addr,
                           input logic [nau_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_mode_readback();
    logic [nau_pkg::DATA_W-1:0] got;
    // leave the bus idle after the preceding transfer, then read act_mode
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_ACT_MODE;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[1:0] !== cur_mode) begin
      $error("act_mode readback: expected %0d, actual %0d", cur_mode, got[1:0]);
      failures++;
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input nau_pkg::act_mode_e mode);
    drain();
    // upper data bits carry noise, only the low two select the mode
    apb_write(ADDR_ACT_MODE, ($urandom() & 32'hFFFF_FFFC) | nau_pkg::DATA_W'(mode));
    cur_mode = mode;
    mode_writes++;
    check_mode_readback();
  endtask

  task automatic offer(input logic [nau_pkg::SAMPLE_W-1:0] x, input logic l,
                       input logic [nau_pkg::SAMPLE_W-1:0] want);
    sample_valid_i <= 1'b1;
    sample_in_i    <= x;
    last_in_i      <= l;
    do @(posedge clk); while (!(sample_valid_i && !sample_stall_o));
    pending_results.push_back('{sample: want, last: l});
    items_per_mode[cur_mode]++;
    if (l) marks_sent++;
  endtask

  // receiver: stall styles in runs of random length, plus one long hold-off
  initial begin
    int style;
    int run;
    int held;
    bit held_once;
    held_once = 1'b0;
    @(posedge rst_ni);
    @(posedge clk);
    forever begin
      if (hold_request && !held_once) begin
        result_stall_i <= 1'b1;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
        held_once = 1'b1;
      end
      style = $urandom_range(0, 3);
      run   = $urandom_range(20, 150);
      repeat (run) begin
        if (hold_request && !held_once) break;
        case (style)
          0: result_stall_i <= 1'b0;
          1: result_stall_i <= ($urandom_range(0, 3) == 0);
          2: result_stall_i <= ($urandom_range(0, 3) != 0);
          default: result_stall_i <= ~result_stall_i;
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: sample_out %h last_out %b", sample_out_o, last_out_o);
        failures++;
      end else begin
        oldest = pending_results.pop_front();
        results_checked++;
        if (sample_out_o !== oldest.sample) begin
          $error("sample_out: expected %h, actual %h", oldest.sample, sample_out_o);
          failures++;
        end
        if (last_out_o !== oldest.last) begin
          $error("last_out: expected %b, actual %b", oldest.last, last_out_o);
          failures++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    longint unsigned e;
    longint unsigned d;
    longint unsigned v;
    int              j;
    int              k;
    int              phase;
    int              burst_left;
    int              gap;
    logic [nau_pkg::SAMPLE_W-1:0] x;
    logic            l;

    // logistic at 1/16 steps over [-8,8] in q16, built symmetrically
    e = 64'd1 << 31;
    for (j = 0; j <= 128; j++) begin
      d = (64'd1 << 31) + e;
      v = ((64'd1 << 47) + (d >> 1)) / d;
      logistic_q16[128 + j] = int'(v);
      logistic_q16[128 - j] = 65536 - int'(v);
      e = (e * EXP_STEP + (64'd1 << 31)) >> 32;
    end

    repeat (11) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    // a write to an unmapped address must leave relu in place
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFE);
    check_mode_readback();

    for (k = 0; k < $size(probes); k++) begin
      if (probes[k].mode != cur_mode) begin
        sample_valid_i <= 1'b0;
        set_mode(probes[k].mode);
      end
      offer(probes[k].sample, probes[k].last,
            probes[k].known ? probes[k].want : activate(cur_mode, probes[k].sample));
    end
    sample_valid_i <= 1'b0;

    burst_left = 0;
    for (phase = 0; phase < $size(phase_plan); phase++) begin
      set_mode(phase_plan[phase]);
      if (phase == 2) hold_request = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap > 0) begin
            sample_valid_i <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                   : $urandom_range(1, 24);
        end
        burst_left--;
        x = pick_sample();
        l = ($urandom_range(0, 7) == 0);
        offer(x, l, activate(cur_mode, x));
      end
      sample_valid_i <= 1'b0;
    end

    drain();
    $display("%0d requests: relu %0d, leaky %0d, sigmoid %0d, tanh %0d; %0d end marks",
             items_per_mode[0] + items_per_mode[1] + items_per_mode[2] + items_per_mode[3],
             items_per_mode[0], items_per_mode[1], items_per_mode[2], items_per_mode[3],
             marks_sent);
    $display("%0d results checked over %0d mode writes, one %0d-cycle receiver hold-off",
             results_checked, mode_writes, HOLD_OFF_CYCLES);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== neural_activation_unit.f =====
rtl/nau_pkg.sv
rtl/nau_front.sv
rtl/nau_queue.sv
rtl/nau_back.sv
rtl/neural_activation_unit.sv
dv/tb_neural_activation_unit.sv
